>>> rtl/core/particle_pair_collision_assert.svh
// Assertion macros shared by the particle pair collision RTL.
`ifndef PARTICLE_PAIR_COLLISION_ASSERT_SVH
`define PARTICLE_PAIR_COLLISION_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PCOL_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("pcol assertion failed");
`define PCOL_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("pcol assertion failed");
`else
`define PCOL_ASSERT(lbl, prop)
`define PCOL_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

>>> rtl/core/pcol_pkg.sv
// Types and constants shared by the particle pair collision modules.
`timescale 1ns / 1ps
`default_nettype none
package pcol_pkg;
	localparam int unsigned NUM_W = 40;
	localparam int unsigned DEN_W = 34;
	localparam int unsigned QUOT_W = 23;
	localparam int unsigned IMP_SHIFT = 14;
	localparam int unsigned HARD_SHIFT = 8;
	localparam logic [7:0] STICKY_LIMIT = 8'd50;
	localparam logic [7:0] HARD_RESET = 8'd255;

	typedef struct packed {
		logic signed [7:0]  vy2;
		logic signed [7:0]  vx2;
		logic signed [15:0] y2;
		logic signed [15:0] x2;
		logic signed [7:0]  vy1;
		logic signed [7:0]  vx1;
		logic signed [15:0] y1;
		logic signed [15:0] x1;
	} pair_t;

	typedef struct packed {
		pair_t              p;
		logic signed [16:0] dx;
		logic signed [16:0] dy;
		logic               dot_neg;
	} carry_t;
endpackage
`default_nettype wire

>>> rtl/core/pcol_front.sv
// Front stages: distances, products, nudge and push, divider operands.
`timescale 1ns / 1ps
`default_nettype none
module pcol_front #(
	parameter int HARD_RADIUS = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire pcol_pkg::pair_t               in_pair,
	input  wire logic                          in_push,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output pcol_pkg::carry_t                   out_carry,
	output logic [pcol_pkg::NUM_W-1:0]         out_num,
	output logic [pcol_pkg::DEN_W-1:0]         out_den
);
	localparam logic signed [16:0] DIAM = 17'(2 * HARD_RADIUS);
	localparam logic [33:0] NEAR_SQ = 34'(2 * HARD_RADIUS * HARD_RADIUS);

	function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
		if (v > 18'sd32767) return 16'sh7fff;
		if (v < -18'sd32768) return 16'sh8000;
		return v[15:0];
	endfunction

	logic v_s1, v_s2, v_s3, en1, en2, en3;
	pcol_pkg::pair_t p_s1, p_s2;
	logic push_s1, push_s2;
	logic signed [16:0] dx_s1, dy_s1, dx_s2, dy_s2;
	logic signed [8:0] rvx_s1, rvy_s1, rvx_s2, rvy_s2;
	logic signed [33:0] xx_s2, yy_s2;
	logic signed [25:0] px_s2, py_s2;
	pcol_pkg::carry_t c_s3;
	logic [pcol_pkg::NUM_W-1:0] num_s3;
	logic [pcol_pkg::DEN_W-1:0] den_s3;

	assign en3 = !v_s3 || out_ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			p_s1 <= in_pair;
			push_s1 <= in_push;
			dx_s1 <= 17'(in_pair.x2) - 17'(in_pair.x1);
			dy_s1 <= 17'(in_pair.y2) - 17'(in_pair.y1);
			rvx_s1 <= 9'(in_pair.vx2) - 9'(in_pair.vx1);
			rvy_s1 <= 9'(in_pair.vy2) - 9'(in_pair.vy1);
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			p_s2 <= p_s1;
			push_s2 <= push_s1;
			dx_s2 <= dx_s1;
			dy_s2 <= dy_s1;
			rvx_s2 <= rvx_s1;
			rvy_s2 <= rvy_s1;
			xx_s2 <= dx_s1 * dx_s1;
			yy_s2 <= dy_s1 * dy_s1;
			px_s2 <= dx_s1 * rvx_s1;
			py_s2 <= dy_s1 * rvy_s1;
		end
	end

	logic [33:0] dsq, dsq_e;
	logic zero, near, inx, iny;
	logic signed [26:0] dot, dot_mag;
	logic signed [17:0] nx, ny, pxv, pyv;
	logic signed [17:0] dx1, dy1, dx2, dy2;
	pcol_pkg::pair_t np;

	always_comb begin
		dsq = $unsigned(xx_s2) + $unsigned(yy_s2);
		zero = (dx_s2 == 17'sd0) && (dy_s2 == 17'sd0);
		dsq_e = zero ? 34'd1 : dsq;
		dot = 27'(px_s2) + 27'(py_s2);
		dot_mag = -dot;
		near = dsq_e < NEAR_SQ;
		inx = near && (dx_s2 < DIAM) && (dx_s2 > -DIAM);
		iny = near && (dy_s2 < DIAM) && (dy_s2 > -DIAM);
		nx = !zero ? 18'sd0 : (rvx_s2 < 9'sd0 ? -18'sd1 : 18'sd1);
		ny = !zero ? 18'sd0 : (rvy_s2 < 9'sd0 ? -18'sd1 : 18'sd1);
		pxv = dx_s2 <= 17'sd0 ? -18'sd1 : 18'sd1;
		pyv = dy_s2 <= 17'sd0 ? -18'sd1 : 18'sd1;
		dx1 = nx - ((inx && push_s2) ? pxv : 18'sd0);
		dy1 = ny - ((iny && push_s2) ? pyv : 18'sd0);
		dx2 = -nx + ((inx && !push_s2) ? pxv : 18'sd0);
		dy2 = -ny + ((iny && !push_s2) ? pyv : 18'sd0);
		np = p_s2;
		np.x1 = sat16(18'(p_s2.x1) + dx1);
		np.y1 = sat16(18'(p_s2.y1) + dy1);
		np.x2 = sat16(18'(p_s2.x2) + dx2);
		np.y2 = sat16(18'(p_s2.y2) + dy2);
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			c_s3.p <= np;
			c_s3.dx <= dx_s2;
			c_s3.dy <= dy_s2;
			c_s3.dot_neg <= dot < 27'sd0;
			num_s3 <= (dot < 27'sd0) ? {dot_mag[25:0], 14'd0} : '0;
			den_s3 <= dsq_e;
		end
	end

	assign out_valid = v_s3;
	assign out_carry = c_s3;
	assign out_num = num_s3;
	assign out_den = den_s3;
endmodule
`default_nettype wire

>>> rtl/core/pcol_div.sv
// Restoring divider pipeline, one quotient bit per stage, payload alongside.
`timescale 1ns / 1ps
`default_nettype none
module pcol_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [pcol_pkg::NUM_W-1:0]    in_num,
	input  wire logic [pcol_pkg::DEN_W-1:0]    in_den,
	input  wire pcol_pkg::carry_t              in_carry,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [pcol_pkg::QUOT_W-1:0]        out_quot,
	output pcol_pkg::carry_t                   out_carry
);
	localparam int QB = pcol_pkg::QUOT_W;
	localparam int WW = pcol_pkg::NUM_W + QB;

	logic v_s [0:QB];
	logic en [1:QB+1];
	logic [pcol_pkg::NUM_W-1:0] r_s [0:QB];
	logic [pcol_pkg::DEN_W-1:0] d_s [0:QB];
	logic [QB-1:0] q_s [0:QB];
	pcol_pkg::carry_t c_s [0:QB];

	assign v_s[0] = in_valid;
	assign r_s[0] = in_num;
	assign d_s[0] = in_den;
	assign q_s[0] = '0;
	assign c_s[0] = in_carry;
	assign en[QB+1] = out_ready;
	assign in_ready = en[1];

	for (genvar k = 1; k <= QB; k++) begin : g_stage
		localparam int SH = QB - k;
		logic [WW-1:0] wd;
		logic ge;
		assign en[k] = !v_s[k] || en[k+1];
		assign wd = WW'(d_s[k-1]) << SH;
		assign ge = WW'(r_s[k-1]) >= wd;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en[k]) begin
				v_s[k] <= v_s[k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en[k]) begin
				r_s[k] <= ge ? r_s[k-1] - wd[pcol_pkg::NUM_W-1:0] : r_s[k-1];
				d_s[k] <= d_s[k-1];
				q_s[k] <= q_s[k-1] | (QB'(ge) << SH);
				c_s[k] <= c_s[k-1];
			end
		end
	end

	assign out_valid = v_s[QB];
	assign out_quot = q_s[QB];
	assign out_carry = c_s[QB];
endmodule
`default_nettype wire

>>> rtl/core/pcol_back.sv
// Back stages: impulse scaling, velocity update, saturation and stickiness.
`timescale 1ns / 1ps
`default_nettype none
module pcol_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [7:0]                    hardness,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [pcol_pkg::QUOT_W-1:0]   in_quot,
	input  wire pcol_pkg::carry_t              in_carry,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output pcol_pkg::pair_t                    out_pair
);
	function automatic logic signed [7:0] sat8(input logic signed [29:0] v);
		if (v > 30'sd127) return 8'sh7f;
		if (v < -30'sd128) return 8'sh80;
		return v[7:0];
	endfunction

	function automatic logic signed [7:0] stick(input logic signed [7:0] v, input logic on);
		return (on && v < 8'sd2 && v > -8'sd2) ? 8'sd0 : v;
	endfunction

	logic v_s1, v_s2, v_s3, en1, en2, en3;
	pcol_pkg::carry_t c_s1, c_s2;
	logic signed [32:0] prod_s1;
	logic signed [41:0] mx_s2, my_s2;
	pcol_pkg::pair_t p_s3;

	assign en3 = !v_s3 || out_ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	logic signed [23:0] qn;
	logic signed [24:0] imp;
	assign qn = -$signed({1'b0, in_quot});
	assign imp = prod_s1[32:pcol_pkg::HARD_SHIFT];

	always_ff @(posedge clk) begin
		if (en1) begin
			c_s1 <= in_carry;
			prod_s1 <= qn * $signed({1'b0, hardness});
		end
		if (en2) begin
			c_s2 <= c_s1;
			mx_s2 <= imp * c_s1.dx;
			my_s2 <= imp * c_s1.dy;
		end
	end

	logic signed [27:0] xi, yi;
	logic sticky_on;
	pcol_pkg::pair_t np;

	always_comb begin
		xi = mx_s2[41:pcol_pkg::IMP_SHIFT];
		yi = my_s2[41:pcol_pkg::IMP_SHIFT];
		sticky_on = hardness < pcol_pkg::STICKY_LIMIT;
		np = c_s2.p;
		if (c_s2.dot_neg) begin
			np.vx1 = stick(sat8(30'(c_s2.p.vx1) + 30'(xi)), sticky_on);
			np.vy1 = stick(sat8(30'(c_s2.p.vy1) + 30'(yi)), sticky_on);
			np.vx2 = stick(sat8(30'(c_s2.p.vx2) - 30'(xi)), sticky_on);
			np.vy2 = stick(sat8(30'(c_s2.p.vy2) - 30'(yi)), sticky_on);
		end
	end

	always_ff @(posedge clk) begin
		if (en3) p_s3 <= np;
	end

	assign out_valid = v_s3;
	assign out_pair = p_s3;
endmodule
`default_nettype wire

>>> rtl/core/particle_pair_collision.sv
// Top level of the particle pair collision pipeline.
// The pipeline has three front stages, 23 divider stages and three back stages.
// One item per cycle unless m_tready stalls; the divider retires one quotient bit per stage.
// Each stage advances when its successor is empty or advancing, so stalls lose nothing.
// Asynchronous reset clears every valid bit and sets hardness to 255.
`timescale 1ns / 1ps
`default_nettype none
`include "particle_pair_collision_assert.svh"
module particle_pair_collision #(
	parameter int HARD_RADIUS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// first_x, first_y, first_vx, first_vy, second_x, second_y, second_vx, second_vy
	input  wire logic [95:0] s_tdata,
	// push_first
	input  wire logic        s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// new_first_x, new_first_y, new_first_vx, new_first_vy,
	// new_second_x, new_second_y, new_second_vx, new_second_vy
	output logic [95:0]      m_tdata
);
	logic [7:0] hardness_q;
	logic fv, fr, dv, dr;
	pcol_pkg::carry_t fc, dc;
	logic [pcol_pkg::NUM_W-1:0] fnum;
	logic [pcol_pkg::DEN_W-1:0] fden;
	logic [pcol_pkg::QUOT_W-1:0] dq;
	pcol_pkg::pair_t op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hardness_q <= pcol_pkg::HARD_RESET;
		end else if (cfg_we) begin
			hardness_q <= cfg_wdata;
		end
	end

	pcol_front #(.HARD_RADIUS(HARD_RADIUS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.in_pair(pcol_pkg::pair_t'(s_tdata)), .in_push(s_tuser),
		.out_valid(fv), .out_ready(fr),
		.out_carry(fc), .out_num(fnum), .out_den(fden)
	);

	pcol_div u_div (
		.clk(clk), .arst_n(arst_n),
		.in_valid(fv), .in_ready(fr),
		.in_num(fnum), .in_den(fden), .in_carry(fc),
		.out_valid(dv), .out_ready(dr),
		.out_quot(dq), .out_carry(dc)
	);

	pcol_back u_back (
		.clk(clk), .arst_n(arst_n), .hardness(hardness_q),
		.in_valid(dv), .in_ready(dr),
		.in_quot(dq), .in_carry(dc),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_pair(op)
	);

	assign m_tdata = 96'(op);

	`PCOL_ASSERT(a_stall_only_when_full, !s_tready |-> (m_tvalid && !m_tready))
	`PCOL_ASSERT_NEXT(a_cfg_taken, cfg_we, hardness_q == $past(cfg_wdata))
	`PCOL_ASSERT_NEXT(a_out_held, m_tvalid && !m_tready, m_tvalid)
endmodule
`default_nettype wire

>>> tb/sv/tb_particle_pair_collision.sv
// Self-checking testbench for the particle pair collision pipeline.
`timescale 1ns / 1ps
`default_nettype none
module tb_particle_pair_collision;
	localparam int HARD_RADIUS = 64;
	localparam int LATENCY = 29;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		pcol_pkg::pair_t p;
		bit    push;
		bit    typed;
		pcol_pkg::pair_t want;
	} pair_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [7:0]  cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;

	pcol_pkg::pair_t pending_pairs[$];
	logic [7:0]  hardness;
	int          tx_idle;
	int          rx_idle;
	bit          hold_req;
	int          mismatches;
	int          cycles;
	pair_row_t   rows[$];

	particle_pair_collision #(.HARD_RADIUS(HARD_RADIUS)) u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint unstick(longint v);
		return (v < 2 && v > -2) ? 0 : v;
	endfunction

	function automatic pcol_pkg::pair_t collide(pcol_pkg::pair_t a, bit push_first,
			logic [7:0] hard);
		longint x1, y1, vx1, vy1, x2, y2, vx2, vy2;
		longint dx, dy, dsq, rvx, rvy, dot, q, imp, xi, yi, h, diam, dir;
		pcol_pkg::pair_t r;
		x1 = a.x1; y1 = a.y1; vx1 = a.vx1; vy1 = a.vy1;
		x2 = a.x2; y2 = a.y2; vx2 = a.vx2; vy2 = a.vy2;
		h = longint'(hard);
		dx = x2 - x1;
		dy = y2 - y1;
		dsq = dx * dx + dy * dy;
		rvx = vx2 - vx1;
		rvy = vy2 - vy1;
		if (dsq == 0) begin
			if (rvx < 0) begin
				x1 -= 1; x2 += 1;
			end else begin
				x1 += 1; x2 -= 1;
			end
			if (rvy < 0) begin
				y1 -= 1; y2 += 1;
			end else begin
				y1 += 1; y2 -= 1;
			end
			dsq = 1;
		end
		dot = dx * rvx + dy * rvy;
		if (dot < 0) begin
			q = (dot * (longint'(1) << pcol_pkg::IMP_SHIFT)) / dsq;
			imp = (q * h) >>> pcol_pkg::HARD_SHIFT;
			xi = (imp * dx) >>> pcol_pkg::IMP_SHIFT;
			yi = (imp * dy) >>> pcol_pkg::IMP_SHIFT;
			vx1 = clip(vx1 + xi, -128, 127);
			vy1 = clip(vy1 + yi, -128, 127);
			vx2 = clip(vx2 - xi, -128, 127);
			vy2 = clip(vy2 - yi, -128, 127);
			if (h < longint'(pcol_pkg::STICKY_LIMIT)) begin
				vx1 = unstick(vx1); vy1 = unstick(vy1);
				vx2 = unstick(vx2); vy2 = unstick(vy2);
			end
		end
		diam = 2 * HARD_RADIUS;
		if (dsq < 2 * HARD_RADIUS * HARD_RADIUS) begin
			if (dx < diam && dx > -diam) begin
				dir = dx <= 0 ? -1 : 1;
				if (push_first) x1 -= dir; else x2 += dir;
			end
			if (dy < diam && dy > -diam) begin
				dir = dy <= 0 ? -1 : 1;
				if (push_first) y1 -= dir; else y2 += dir;
			end
		end
		r.x1 = 16'(clip(x1, -32768, 32767));
		r.y1 = 16'(clip(y1, -32768, 32767));
		r.x2 = 16'(clip(x2, -32768, 32767));
		r.y2 = 16'(clip(y2, -32768, 32767));
		r.vx1 = 8'(vx1); r.vy1 = 8'(vy1); r.vx2 = 8'(vx2); r.vy2 = 8'(vy2);
		return r;
	endfunction

	function automatic pcol_pkg::pair_t mk(int x1, int y1, int vx1, int vy1,
			int x2, int y2, int vx2, int vy2);
		pcol_pkg::pair_t r;
		r.x1 = 16'(x1); r.y1 = 16'(y1); r.vx1 = 8'(vx1); r.vy1 = 8'(vy1);
		r.x2 = 16'(x2); r.y2 = 16'(y2); r.vx2 = 8'(vx2); r.vy2 = 8'(vy2);
		return r;
	endfunction

	function automatic pcol_pkg::pair_t random_pair();
		pcol_pkg::pair_t r;
		int sel;
		sel = int'($urandom_range(9));
		r = {$urandom, $urandom, $urandom};
		if (sel == 1) begin
			r.x2 = r.x1;
			r.y2 = r.y1;
		end else if (sel >= 2) begin
			r.x2 = 16'(r.x1 + $signed($urandom_range(300)) - 150);
			r.y2 = 16'(r.y1 + $signed($urandom_range(300)) - 150);
			if (sel >= 7) begin
				r.vx1 = 8'($signed($urandom_range(8)) - 4);
				r.vy1 = 8'($signed($urandom_range(8)) - 4);
				r.vx2 = 8'($signed($urandom_range(8)) - 4);
				r.vy2 = 8'($signed($urandom_range(8)) - 4);
			end
		end
		return r;
	endfunction

	task automatic send(pcol_pkg::pair_t p, bit push, pcol_pkg::pair_t want);
		while ($urandom_range(99) < tx_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= p;
		s_tuser <= push;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_pairs.push_back(want);
		@(negedge clk);
	endtask

	task automatic write_hardness(logic [7:0] v);
		s_tvalid <= 1'b0;
		while (pending_pairs.size() != 0) @(negedge clk);
		repeat (LATENCY + 6) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		hardness = v;
	endtask

	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			m_tready <= 1'b0;
			for (int n = 0; n < 300; n++) @(negedge clk);
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle);
		end
	end

	always @(posedge clk) begin
		pcol_pkg::pair_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_pairs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected item %h with nothing pending.", got);
			end else begin
				want = pending_pairs.pop_front();
				if (got.x1 !== want.x1 || got.y1 !== want.y1 || got.vx1 !== want.vx1 ||
						got.vy1 !== want.vy1 || got.x2 !== want.x2 || got.y2 !== want.y2 ||
						got.vx2 !== want.vx2 || got.vy2 !== want.vy2) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"Mismatch: expected %0d %0d %0d %0d %0d %0d %0d %0d,",
							" got %0d %0d %0d %0d %0d %0d %0d %0d"},
							want.x1, want.y1, want.vx1, want.vy1,
							want.x2, want.y2, want.vx2, want.vy2,
							got.x1, got.y1, got.vx1, got.vy1,
							got.x2, got.y2, got.vx2, got.vy2);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		logic [7:0] settings[6];
		pcol_pkg::pair_t p;
		bit push;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		hold_req = 1'b0;
		mismatches = 0;
		cycles = 0;
		hardness = pcol_pkg::HARD_RESET;
		tx_idle = 27;
		rx_idle = 76;
		settings = '{8'd0, 8'd255, 8'd49, 8'd50, 8'd1, 8'd0};
		settings[5] = 8'($urandom_range(255));

		rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, 1'b1, mk(2, 2, 0, 0, -1, -1, 0, 0)});
		rows.push_back('{mk(-32768, -32768, 127, -128, 32767, 32767, 127, -128), 1'b0, 1'b1,
			mk(-32768, -32768, 127, -128, 32767, 32767, 127, -128)});
		rows.push_back('{mk(32767, 32767, 127, 127, 32767, 32767, -128, -128), 1'b0, 1'b0, '0});
		rows.push_back('{mk(-32768, -32768, -128, -128, -32768, -32768, 127, 127), 1'b1, 1'b0,
			'0});
		rows.push_back('{mk(0, 0, 127, 0, 10, 0, -128, 0), 1'b1, 1'b0, '0});
		rows.push_back('{mk(5, 100, 0, -128, 5, 0, 0, 127), 1'b0, 1'b0, '0});
		rows.push_back('{mk(0, 0, 3, 3, 127, 0, -3, -3), 1'b1, 1'b0, '0});
		rows.push_back('{mk(0, 0, 3, 3, -127, 1, 9, 0), 1'b0, 1'b0, '0});
		rows.push_back('{mk(0, 0, 5, 0, 128, 0, -5, 0), 1'b1, 1'b0, '0});
		rows.push_back('{mk(0, 0, 1, 1, 64, 64, -1, -1), 1'b0, 1'b0, '0});
		rows.push_back('{mk(0, 0, 1, 1, 64, 63, -1, -1), 1'b1, 1'b0, '0});
		rows.push_back('{mk(200, 300, 1, -1, 180, 320, -1, 1), 1'b0, 1'b0, '0});

		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		for (int pass = 0; pass < 2; pass++) begin
			foreach (rows[i])
				send(rows[i].p, rows[i].push,
					rows[i].typed ? rows[i].want : collide(rows[i].p, rows[i].push, hardness));
			if (pass == 0) write_hardness(8'd20);
		end

		for (int seg = 0; seg < 6; seg++) begin
			write_hardness(settings[seg]);
			tx_idle = (seg < 2) ? 27 : (seg < 4) ? 76 : 0;
			rx_idle = (seg < 2) ? 76 : (seg < 4) ? 27 : 0;
			if (seg == 4) hold_req = 1'b1;
			for (int n = 0; n < 200; n++) begin
				p = random_pair();
				push = 1'($urandom_range(1));
				send(p, push, collide(p, push, hardness));
			end
		end
		s_tvalid <= 1'b0;

		while (pending_pairs.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire
